// ===== rtl/core/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg - shared types and helpers for the box transform
// Q16.16 types, register codes, reset values and the rounding and
// saturation helpers used by the axis lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

	typedef logic signed [31:0] q16_t;   // Q16.16 value
	typedef logic signed [63:0] prod_t;  // raw 32x32 product, Q32.32
	typedef logic signed [47:0] rnd_t;   // product shifted back to Q16.16, full range
	typedef logic signed [49:0] acc_t;   // offset plus three terms, exact

	localparam int NUM_REGS  = 6;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [63:0]          cfg_word_t;

	localparam cfg_idx_t REG_X_A = 3'd0;
	localparam cfg_idx_t REG_X_B = 3'd1;
	localparam cfg_idx_t REG_Y_A = 3'd2;
	localparam cfg_idx_t REG_Y_B = 3'd3;
	localparam cfg_idx_t REG_Z_A = 3'd4;
	localparam cfg_idx_t REG_Z_B = 3'd5;

	// identity matrix, zero offset
	localparam cfg_word_t REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	// load enables of the five pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} aabb_ld_t;

	// shift right by 16, rounding toward zero
	function automatic rnd_t trunc_q16(prod_t p);
		rnd_t t;
		t = p[63:16];
		if (p[63] && (p[15:0] != 16'h0000)) begin
			t = t + rnd_t'(1);
		end
		return t;
	endfunction

	// clamp to the signed 32-bit range
	function automatic q16_t sat_q16(acc_t s);
		q16_t r;
		if (s > acc_t'(32'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (s < -acc_t'(33'sh0_8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aabb_in_if.sv =====
// ----------------------------------------------------------------------------
// aabb_in_if - input box channel
// Valid/ready channel carrying the min and max corners of one box.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabb_in_if import aabb_pkg::*; ();
	logic valid;
	logic ready;
	q16_t in_min_x;
	q16_t in_min_y;
	q16_t in_min_z;
	q16_t in_max_x;
	q16_t in_max_y;
	q16_t in_max_z;

	modport source (
		output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
		input  ready
	);
	modport sink (
		input  valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/aabb_out_if.sv =====
// ----------------------------------------------------------------------------
// aabb_out_if - output box channel
// Valid/ready channel carrying the transformed min and max corners.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabb_out_if import aabb_pkg::*; ();
	logic valid;
	logic ready;
	q16_t out_min_x;
	q16_t out_min_y;
	q16_t out_min_z;
	q16_t out_max_x;
	q16_t out_max_y;
	q16_t out_max_z;

	modport source (
		output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		input  ready
	);
	modport sink (
		input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/aabb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aabb_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and 64-bit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabb_cfg_if import aabb_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_word_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aabb_lane.sv =====
// ----------------------------------------------------------------------------
// aabb_lane - datapath of one output axis
// Multiply, round, min/max select, sum and saturate over five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_lane import aabb_pkg::*; (
	input  wire logic       clk,
	input  wire aabb_ld_t   ld,
	input  wire q16_t [2:0] coef,
	input  wire q16_t       offset,
	input  wire q16_t [2:0] lo,
	input  wire q16_t [2:0] hi,
	output q16_t            res_min,
	output q16_t            res_max
);

	prod_t pa_s1 [3];
	prod_t pb_s1 [3];
	rnd_t  ra_s2 [3];
	rnd_t  rb_s2 [3];
	rnd_t  tmin_s3 [3];
	rnd_t  tmax_s3 [3];
	acc_t  smin_s4;
	acc_t  smax_s4;
	q16_t  min_s5;
	q16_t  max_s5;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (ld.s1) begin
				pa_s1[j] <= prod_t'(signed'(coef[j])) * prod_t'(signed'(lo[j]));
				pb_s1[j] <= prod_t'(signed'(coef[j])) * prod_t'(signed'(hi[j]));
			end
			if (ld.s2) begin
				ra_s2[j] <= trunc_q16(pa_s1[j]);
				rb_s2[j] <= trunc_q16(pb_s1[j]);
			end
			if (ld.s3) begin
				// smaller term to the minimum, larger to the maximum
				if (ra_s2[j] < rb_s2[j]) begin
					tmin_s3[j] <= ra_s2[j];
					tmax_s3[j] <= rb_s2[j];
				end else begin
					tmin_s3[j] <= rb_s2[j];
					tmax_s3[j] <= ra_s2[j];
				end
			end
		end
		if (ld.s4) begin
			smin_s4 <= (acc_t'(offset) + acc_t'(tmin_s3[0]))
				+ (acc_t'(tmin_s3[1]) + acc_t'(tmin_s3[2]));
			smax_s4 <= (acc_t'(offset) + acc_t'(tmax_s3[0]))
				+ (acc_t'(tmax_s3[1]) + acc_t'(tmax_s3[2]));
		end
		if (ld.s5) begin
			min_s5 <= sat_q16(smin_s4);
			max_s5 <= sat_q16(smax_s4);
		end
	end

	assign res_min = min_s5;
	assign res_max = max_s5;

endmodule

`default_nettype wire

// ===== rtl/core/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform - affine transform of an axis-aligned box
// Maps a Q16.16 box by a 3x3 matrix and offset, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   box_in  : valid/ready sink, one box (min and max corners) per transaction.
//   box_out : valid/ready source, one transformed box per input transaction.
//   cfg     : valid/ready write port, index 0..5 selects a 64-bit register
//             holding two Q16.16 halves; other indexes are dropped. cfg.ready
//             is always high. Write only while the pipeline is empty.
//   A box passes five register stages: multiply, round toward zero, min/max
//   select, four-term sum, saturate. box_out.valid rises once the box has
//   been registered in the saturate stage, and it leaves at a rising edge
//   with box_out.ready high. Throughput is one box per cycle while box_out
//   is not stalled, as boxes share no state; the first stage holds the
//   eighteen 32x32 multipliers.
//   Each stage holds its own valid bit and loads when it is empty or its
//   content moves on, so bubbles collapse; a stall on box_out holds every
//   full stage without dropping or repeating a transaction.
//   Reset clears all valid bits and loads the identity matrix with zero
//   offset.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform import aabb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	aabb_cfg_if.sink  cfg,
	aabb_in_if.sink   box_in,
	aabb_out_if.source box_out
);

	cfg_word_t cfg_q [NUM_REGS];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	aabb_ld_t ld;

	q16_t [2:0] in_lo;
	q16_t [2:0] in_hi;
	q16_t lane_min [3];
	q16_t lane_max [3];

	// Configuration registers: accept every write, drop unknown indexes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				cfg_q[r] <= REG_RESET[r];
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_X_A: cfg_q[0] <= cfg.data;
				REG_X_B: cfg_q[1] <= cfg.data;
				REG_Y_A: cfg_q[2] <= cfg.data;
				REG_Y_B: cfg_q[3] <= cfg.data;
				REG_Z_A: cfg_q[4] <= cfg.data;
				REG_Z_B: cfg_q[5] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Ready chain: a stage can load when it is empty or its content moves on.
	assign rdy5 = !valid_s5 || box_out.ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign box_in.ready = rdy1;

	// Load payload only when a real transaction moves in.
	assign ld.s1 = rdy1 && box_in.valid;
	assign ld.s2 = rdy2 && valid_s1;
	assign ld.s3 = rdy3 && valid_s2;
	assign ld.s4 = rdy4 && valid_s3;
	assign ld.s5 = rdy5 && valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= box_in.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	assign in_lo = {box_in.in_min_z, box_in.in_min_y, box_in.in_min_x};
	assign in_hi = {box_in.in_max_z, box_in.in_max_y, box_in.in_max_x};

	// One lane per output axis; the lane's coefficients and offset come
	// from the register pair of that axis.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		q16_t [2:0] coef;

		assign coef = {cfg_q[2*i+1][31:0], cfg_q[2*i][63:32], cfg_q[2*i][31:0]};

		aabb_lane u_lane (
			.clk     (clk),
			.ld      (ld),
			.coef    (coef),
			.offset  (cfg_q[2*i+1][63:32]),
			.lo      (in_lo),
			.hi      (in_hi),
			.res_min (lane_min[i]),
			.res_max (lane_max[i])
		);
	end

	assign box_out.valid     = valid_s5;
	assign box_out.out_min_x = lane_min[0];
	assign box_out.out_min_y = lane_min[1];
	assign box_out.out_min_z = lane_min[2];
	assign box_out.out_max_x = lane_max[0];
	assign box_out.out_max_y = lane_max[1];
	assign box_out.out_max_z = lane_max[2];

endmodule

`default_nettype wire

// ===== rtl/core/aabb_checker.sv =====
// ----------------------------------------------------------------------------
// aabb_checker - port-level checks for the box transform
// Concurrent assertions on the top-level channels, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_checker import aabb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire q16_t out_min_x,
	input wire q16_t out_min_y,
	input wire q16_t out_min_z,
	input wire q16_t out_max_x,
	input wire q16_t out_max_y,
	input wire q16_t out_max_z
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("box_out.valid dropped while stalled");

	// min terms never exceed max terms, and saturation keeps the order
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
			&& (out_min_z <= out_max_z))
		else $error("transformed box has min above max");

	// pipeline is empty while reset is held
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("box_out.valid high during reset");

	// configuration writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg.ready low");

endmodule

bind aabb_affine_transform aabb_checker u_aabb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.out_valid (box_out.valid),
	.out_ready (box_out.ready),
	.out_min_x (box_out.out_min_x),
	.out_min_y (box_out.out_min_y),
	.out_min_z (box_out.out_min_z),
	.out_max_x (box_out.out_max_x),
	.out_max_y (box_out.out_max_y),
	.out_max_z (box_out.out_max_z)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for aabb_affine_transform
// Streams boxes through the transform under several matrix settings and
// with random idling on both channels. A scoreboard computes the expected
// transformed box for every accepted input transaction and checks the
// output stream in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import aabb_pkg::*;

	// one box: fields 0..2 are the min corner x,y,z, fields 3..5 the max corner
	typedef logic [5:0][31:0] box_t;

	localparam int AXES           = 3;
	localparam int MAX_BASE       = 3;
	localparam int RESET_CYCLES   = 6;
	localparam int DRAIN_GAP      = 8;     // a little more than the five-stage pipeline needs to empty
	localparam int LONG_STALL     = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int SEG_ITEMS      = 250;

	localparam cfg_idx_t REG_ORDER [NUM_REGS] = '{
		REG_X_A, REG_X_B, REG_Y_A, REG_Y_B, REG_Z_A, REG_Z_B
	};
	// indexes past the register file; writes there must be dropped
	localparam cfg_idx_t REG_SPARE_LO = 3'd6;
	localparam cfg_idx_t REG_SPARE_HI = 3'd7;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the matrix registers, predicts the
	// transformed box for each input transaction and checks results in order.
	// ------------------------------------------------------------------------
	class box_transform_scoreboard;
		cfg_word_t matrix_regs [NUM_REGS];
		box_t      predicted_boxes [$];
		int        failures;
		string     field_names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

		function new();
			foreach (matrix_regs[k]) matrix_regs[k] = REG_RESET[k];
			failures = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_word_t data);
			if (idx < NUM_REGS) matrix_regs[idx] = data;
		endfunction

		// Q16.16 product, shifted back with rounding toward zero, full width
		function longint scaled_product(logic [31:0] coef, logic [31:0] val);
			longint prod;
			prod = longint'($signed(coef)) * longint'($signed(val));
			if (prod < 0) return -((-prod) >>> 16);
			return prod >>> 16;
		endfunction

		function logic [31:0] clamp_q16(longint s);
			if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
			if (s < -64'sd2147483648) return 32'h8000_0000;
			return s[31:0];
		endfunction

		function box_t transform(box_t b);
			box_t        r;
			cfg_word_t   ra;
			cfg_word_t   rb;
			logic [31:0] c [AXES];
			longint      lo_sum;
			longint      hi_sum;
			longint      p_lo;
			longint      p_hi;
			for (int i = 0; i < AXES; i++) begin
				ra = matrix_regs[2 * i];
				rb = matrix_regs[2 * i + 1];
				c[0] = ra[31:0];
				c[1] = ra[63:32];
				c[2] = rb[31:0];
				lo_sum = longint'($signed(rb[63:32]));
				hi_sum = lo_sum;
				for (int j = 0; j < AXES; j++) begin
					p_lo = scaled_product(c[j], b[j]);
					p_hi = scaled_product(c[j], b[j + MAX_BASE]);
					if (p_lo < p_hi) begin
						lo_sum += p_lo;
						hi_sum += p_hi;
					end else begin
						lo_sum += p_hi;
						hi_sum += p_lo;
					end
				end
				r[i] = clamp_q16(lo_sum);
				r[i + MAX_BASE] = clamp_q16(hi_sum);
			end
			return r;
		endfunction

		function void fail(string msg);
			failures++;
			if (failures <= REPORT_LIMIT) $display("[%0t] error: %s", $realtime, msg);
		endfunction

		function void note_box_in(box_t b);
			predicted_boxes.push_back(transform(b));
		endfunction

		function void check_box_out(box_t got);
			box_t want;
			if (predicted_boxes.size() == 0) begin
				fail($sformatf("output box %h with none pending", got));
				return;
			end
			want = predicted_boxes.pop_front();
			for (int k = 0; k < 6; k++) begin
				if (got[k] !== want[k])
					fail($sformatf("%s: expected %h, got %h", field_names[k], want[k], got[k]));
			end
		endfunction

		function int pending();
			return predicted_boxes.size();
		endfunction

		function void check_leftover();
			if (predicted_boxes.size() != 0)
				fail($sformatf("%0d boxes never came out", predicted_boxes.size()));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aabb_cfg_if cfg_bus ();
	aabb_in_if  box_in_bus ();
	aabb_out_if box_out_bus ();

	aabb_affine_transform u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.box_in  (box_in_bus),
		.box_out (box_out_bus)
	);

	box_transform_scoreboard sb = new();

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int          stall_asks;      // bumped by the stimulus to request a long hold-off
	int          stall_done;      // bumped by the receiver once it has served one
	int          quiet_cycles;
	cfg_word_t   reg_plan [NUM_REGS];

	// ------------------------------------------------------------------------
	// Monitors: sample at the rising edge, so every value read is the one
	// that the edge accepted.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
	end

	always @(posedge clk) begin
		if (arst_n && box_in_bus.valid && box_in_bus.ready)
			sb.note_box_in({box_in_bus.in_max_z, box_in_bus.in_max_y, box_in_bus.in_max_x,
			                box_in_bus.in_min_z, box_in_bus.in_min_y, box_in_bus.in_min_x});
	end

	always @(posedge clk) begin
		if (arst_n && box_out_bus.valid && box_out_bus.ready)
			sb.check_box_out({box_out_bus.out_max_z, box_out_bus.out_max_y,
			                  box_out_bus.out_max_x, box_out_bus.out_min_z,
			                  box_out_bus.out_min_y, box_out_bus.out_min_x});
	end

	// Watchdog: end the run when no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if ((cfg_bus.valid && cfg_bus.ready) || (box_in_bus.valid && box_in_bus.ready) ||
		    (box_out_bus.valid && box_out_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random back-pressure, plus a long hold-off on request. The
	// hold-off is counted here so the sender keeps offering boxes meanwhile
	// and the pipe fills up and stalls its input.
	// ------------------------------------------------------------------------
	initial begin
		box_out_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_asks != stall_done) begin
				box_out_bus.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stall_done++;
			end else begin
				box_out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic box_t make_box(q16_t mnx, q16_t mny, q16_t mnz,
	                                  q16_t mxx, q16_t mxy, q16_t mxz);
		return {mxz, mxy, mxx, mnz, mny, mnx};
	endfunction

	// Mix of corner values, full-range noise and values centered on zero
	// within +/- 2^(span_bits-1) LSBs.
	function automatic q16_t rand_q16(int unsigned span_bits);
		int unsigned roll;
		logic [31:0] mask;
		roll = $urandom_range(99);
		mask = (32'd1 << span_bits) - 32'd1;
		if (roll < 8) begin
			case ($urandom_range(4))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'h0000_0000;
				3:       return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		if (roll < 25) return $urandom;
		return ($urandom & mask) - (32'd1 << (span_bits - 1));
	endfunction

	// Mostly well-formed boxes (min <= max), some inverted or unordered ones.
	function automatic box_t rand_box();
		box_t   b;
		longint top;
		for (int j = 0; j < AXES; j++) begin
			b[j] = rand_q16(24);
			if ($urandom_range(9) != 0) begin
				top = longint'($signed(b[j])) + longint'($urandom_range(0, 32'h0010_0000));
				if (top > 64'sd2147483647) top = 64'sd2147483647;
				b[j + MAX_BASE] = top[31:0];
			end else begin
				b[j + MAX_BASE] = rand_q16(24);
			end
		end
		return b;
	endfunction

	// Hold valid across back-to-back boxes; drop it only for a random gap.
	task automatic send_box(box_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			box_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		box_in_bus.valid    <= 1'b1;
		box_in_bus.in_min_x <= b[0];
		box_in_bus.in_min_y <= b[1];
		box_in_bus.in_min_z <= b[2];
		box_in_bus.in_max_x <= b[3];
		box_in_bus.in_max_y <= b[4];
		box_in_bus.in_max_z <= b[5];
		@(posedge clk);
		while (!box_in_bus.ready) @(posedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count) send_box(rand_box());
	endtask

	// Leaves valid high so a following write goes out on the next cycle.
	task automatic write_reg(cfg_idx_t idx, cfg_word_t data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	task automatic program_plan();
		for (int k = 0; k < NUM_REGS; k++) write_reg(REG_ORDER[k], reg_plan[k]);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic program_uniform(cfg_word_t w);
		foreach (reg_plan[k]) reg_plan[k] = w;
		program_plan();
	endtask

	// Random matrix: small coefficients most of the time so that results
	// are not all saturated, with corner values and noise mixed in.
	task automatic program_random();
		for (int i = 0; i < AXES; i++) begin
			reg_plan[2 * i]     = {rand_q16(19), rand_q16(19)};
			reg_plan[2 * i + 1] = {rand_q16(27), rand_q16(19)};
		end
		program_plan();
	endtask

	// Stop offering boxes and wait until every predicted box has come out,
	// then let the pipe settle before touching the registers.
	task automatic wait_drain();
		box_in_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_X_A;
		cfg_bus.data        = '0;
		box_in_bus.valid    = 1'b0;
		box_in_bus.in_min_x = '0;
		box_in_bus.in_min_y = '0;
		box_in_bus.in_min_z = '0;
		box_in_bus.in_max_x = '0;
		box_in_bus.in_max_y = '0;
		box_in_bus.in_max_z = '0;
		quiet_cycles        = 0;
		stall_asks          = 0;
		stall_done          = 0;
		src_idle_pct        = 21;
		sink_idle_pct       = 48;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Identity after reset: zero box, full-range box, inverted box,
		// and a box straddling zero by one LSB.
		send_box(make_box('0, '0, '0, '0, '0, '0));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_box(make_box(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
		                  32'hFFFC_C000, 32'hFFFC_C000, 32'hFFFC_C000));
		send_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		                  32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		wait_drain();

		// Mixed-sign fractional matrix: negative products with a remainder
		// must round toward zero, not down.
		reg_plan[0] = {32'hFFFE_0000, 32'h0001_8000};   // -2.0, 1.5
		reg_plan[1] = {32'h000A_0000, 32'h0000_4000};   // offset 10.0, 0.25
		reg_plan[2] = {32'h0000_0000, 32'hFFFE_8000};   // 0, -1.5
		reg_plan[3] = {32'hFFF8_8000, 32'h0003_0000};   // offset -7.5, 3.0
		reg_plan[4] = {32'hFFFF_FFFF, 32'h0000_0001};   // -1 LSB, +1 LSB
		reg_plan[5] = {32'h0000_0000, 32'hFFFD_4000};   // offset 0, -2.75
		program_plan();
		send_box(make_box(32'hFFFD_0000, 32'h0002_8000, 32'hFFFF_FFFD,
		                  32'h0004_0000, 32'h0008_C000, 32'h0000_0005));
		send_box(make_box(32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
		                  32'h0000_0003, 32'h0000_0003, 32'h0000_0003));
		send_box(make_box(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0007,
		                  32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0001));
		wait_drain();

		// Most negative coefficients and offsets: drive both saturation limits.
		program_uniform(64'h8000_0000_8000_0000);
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_box(make_box('0, '0, '0, '0, '0, '0));
		send_box(make_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
		                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		wait_drain();

		// Most positive coefficients and offsets.
		program_uniform(64'h7FFF_FFFF_7FFF_FFFF);
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_box(make_box('0, '0, '0, '0, '0, '0));
		send_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		wait_drain();

		// Writes past the register file must leave the matrix untouched.
		write_reg(REG_SPARE_LO, 64'hDEAD_BEEF_1234_5678);
		write_reg(REG_SPARE_HI, '1);
		cfg_bus.valid <= 1'b0;
		send_box(make_box(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
		                  32'h0002_0000, 32'h0000_0000, 32'h0003_0000));
		send_box(rand_box());

		// Random part: three idling profiles, two matrices each. The long
		// receiver hold-off lands on the first segment without idling.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle_pct = 21; sink_idle_pct = 48; end
				1:       begin src_idle_pct = 48; sink_idle_pct = 21; end
				default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				wait_drain();
				program_random();
				if (phase == 2 && seg == 0) stall_asks++;
				send_random(SEG_ITEMS);
			end
		end

		wait_drain();
		sb.check_leftover();
		if (sb.failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
